// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("property violated");
// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ----- rtl/obst_pkg.sv -----
// types, constants and helpers for the optimal bst table block
package obst_pkg;

  // default sizes
  localparam int MAX_KEYS_DEF    = 32;
  localparam int WEIGHT_BITS_DEF = 16;

  // fixed port widths
  localparam int WEIGHT_IN_BITS = 16;
  localparam int RANGE_BITS     = 6;
  localparam int STATUS_BITS    = 2;
  localparam int COST_OUT_BITS  = 27;
  localparam int ROOT_OUT_BITS  = 6;

  // width used when saturating an internal cost
  localparam int COST_CALC_BITS = 64;
  localparam logic [COST_OUT_BITS-1:0] COST_OUT_MAX = '1;

  // item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] STAT_LOADED    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_RANGE     = 2'd2;
  localparam logic [STATUS_BITS-1:0] STAT_NOT_READY = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN_RD,
    ST_SPAN,
    ST_CAND,
    ST_DRAIN,
    ST_WRITE,
    ST_FIN_RD,
    ST_FIN,
    ST_QUERY,
    ST_RESP
  } state_t;

  // clamp an internal cost to the output range
  function automatic logic [COST_OUT_BITS-1:0] sat_cost(input logic [COST_CALC_BITS-1:0] c);
    if (c > COST_CALC_BITS'(COST_OUT_MAX)) begin
      return COST_OUT_MAX;
    end
    return c[COST_OUT_BITS-1:0];
  endfunction

endpackage

// ----- rtl/optimal_bst_cost_root_tables.sv -----
// top level: optimal bst cost and root tables with a shared candidate unit
//
// One input channel (in_valid/in_ready) carries load and query items, one
// output channel (out_valid/out_ready) returns exactly one result per item.
// A load writes the next key weight and its prefix sum; a load marked last
// then fills the cost and root tables diagonal by diagonal. One add and
// compare unit walks the candidate roots, one per cycle, fed by the two read
// ports of the table ram; each key range also passes through the prefix-sum
// read, span, drain and write-back states. The block takes no new item while
// one is at work. The result sits in an output register; the next item is
// taken while it waits, and that item's result holds back until the register
// is free. Reset (rst, synchronous) clears the key count and the ready flag;
// the tables themselves are not cleared and only written entries are used.
`include "assert_macros.svh"

module optimal_bst_cost_root_tables #(
  parameter int MAX_KEYS    = obst_pkg::MAX_KEYS_DEF,
  parameter int WEIGHT_BITS = obst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 func,
  input  logic [obst_pkg::WEIGHT_IN_BITS-1:0]  weight,
  input  logic                                 last,
  input  logic [obst_pkg::RANGE_BITS-1:0]      range_first,
  input  logic [obst_pkg::RANGE_BITS-1:0]      range_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [obst_pkg::STATUS_BITS-1:0]     status,
  output logic [obst_pkg::COST_OUT_BITS-1:0]   cost,
  output logic [obst_pkg::ROOT_OUT_BITS-1:0]   root
);

  // derived sizes
  localparam int KB = $clog2(MAX_KEYS + 1);
  localparam int AB = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int COST_BITS = WEIGHT_BITS + 2 * KB;
  localparam int CW = COST_BITS + KB;
  localparam int PB = WEIGHT_BITS + KB;
  localparam int QW = ((KB > obst_pkg::RANGE_BITS) ? KB : obst_pkg::RANGE_BITS) + 1;

  obst_pkg::state_t state, state_next;

  // control registers
  logic [KB-1:0] key_count, key_count_next;
  logic          tables_ready, tables_ready_next;
  logic [PB-1:0] psum, psum_next;
  logic [KB-1:0] d, d_next;
  logic [KB-1:0] i0, i0_next;
  logic [KB-1:0] k0, k0_next;
  logic [PB-1:0] span, span_next;

  // candidate pipeline
  logic          ev_valid, ev_valid_next;
  logic [KB-1:0] ev_k, ev_k_next;
  logic          ev_lempty, ev_lempty_next;
  logic          ev_rempty, ev_rempty_next;
  logic [COST_BITS-1:0] best;
  logic [KB-1:0]        best_k;

  // result staging
  logic [obst_pkg::STATUS_BITS-1:0]   res_status, res_status_next;
  logic [obst_pkg::COST_OUT_BITS-1:0] res_cost, res_cost_next;
  logic [obst_pkg::ROOT_OUT_BITS-1:0] res_root, res_root_next;
  logic                               out_load;

  // ram ports
  logic            cram_we;
  logic [2*AB-1:0] cram_waddr, cram_raddr_a, cram_raddr_b;
  logic [CW-1:0]   cram_wdata, cram_rda, cram_rdb;
  logic            pram_we;
  logic [AB-1:0]   pram_waddr, pram_raddr_a, pram_raddr_b;
  logic [PB-1:0]   pram_wdata, pram_rda, pram_rdb;

  // helpers
  logic [WEIGHT_BITS-1:0] w_in;
  logic [KB-1:0]          eff_count, cnt_inc, j0;
  logic [PB-1:0]          eff_sum, sum_inc;
  logic [QW-1:0]          q_first, q_end, q_cnt;
  logic                   q_bad, q_empty;
  logic [COST_BITS-1:0]   cand_left, cand_right, cand_sum;
  logic                   cand_take;

  // weight limited to the configured width
  assign w_in      = WEIGHT_BITS'(weight);
  // a load after the tables are built starts a new key set
  assign eff_count = tables_ready ? '0 : key_count;
  assign eff_sum   = tables_ready ? '0 : psum;
  assign cnt_inc   = eff_count + KB'(1);
  assign sum_inc   = eff_sum + PB'(w_in);
  assign j0        = i0 + d;

  // query range checks
  assign q_first = QW'(range_first);
  assign q_end   = QW'(range_end);
  assign q_cnt   = QW'(key_count);
  assign q_bad   = (q_first == '0) || (q_first > q_cnt + QW'(1)) ||
                   (q_end > q_cnt) || (q_end + QW'(1) < q_first);
  assign q_empty = (q_end + QW'(1) == q_first);

  // shared candidate unit: left plus right cost, strict compare
  assign cand_left  = ev_lempty ? '0 : cram_rda[COST_BITS-1:0];
  assign cand_right = ev_rempty ? '0 : cram_rdb[COST_BITS-1:0];
  assign cand_sum   = cand_left + cand_right;
  assign cand_take  = ev_valid && ((ev_k == i0) || (cand_sum < best));

  assign in_ready = (state == obst_pkg::ST_IDLE);

  // cost and root table, row i-1 and column j-1 form the address
  obst_ram #(
    .WIDTH (CW),
    .DEPTH (2 ** (2 * AB))
  ) u_cost_ram (
    .clk     (clk),
    .we      (cram_we),
    .waddr   (cram_waddr),
    .wdata   (cram_wdata),
    .raddr_a (cram_raddr_a),
    .rdata_a (cram_rda),
    .raddr_b (cram_raddr_b),
    .rdata_b (cram_rdb)
  );

  // prefix sums, entry x holds the weight sum of keys 1..x+1
  obst_ram #(
    .WIDTH (PB),
    .DEPTH (2 ** AB)
  ) u_prefix_ram (
    .clk     (clk),
    .we      (pram_we),
    .waddr   (pram_waddr),
    .wdata   (pram_wdata),
    .raddr_a (pram_raddr_a),
    .rdata_a (pram_rda),
    .raddr_b (pram_raddr_b),
    .rdata_b (pram_rdb)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= obst_pkg::ST_IDLE;
      key_count    <= '0;
      tables_ready <= 1'b0;
      psum         <= '0;
      ev_valid     <= 1'b0;
    end else begin
      state        <= state_next;
      key_count    <= key_count_next;
      tables_ready <= tables_ready_next;
      psum         <= psum_next;
      ev_valid     <= ev_valid_next;
    end
  end

  // loop indices and staging
  always_ff @(posedge clk) begin
    d          <= d_next;
    i0         <= i0_next;
    k0         <= k0_next;
    span       <= span_next;
    ev_k       <= ev_k_next;
    ev_lempty  <= ev_lempty_next;
    ev_rempty  <= ev_rempty_next;
    res_status <= res_status_next;
    res_cost   <= res_cost_next;
    res_root   <= res_root_next;
  end

  // best candidate so far
  always_ff @(posedge clk) begin
    if (cand_take) begin
      best   <= cand_sum;
      best_k <= ev_k;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status <= res_status;
      cost   <= res_cost;
      root   <= res_root;
    end
  end

  // sequencer
  always_comb begin
    state_next        = state;
    key_count_next    = key_count;
    tables_ready_next = tables_ready;
    psum_next         = psum;
    d_next            = d;
    i0_next           = i0;
    k0_next           = k0;
    span_next         = span;
    ev_valid_next     = 1'b0;
    ev_k_next         = ev_k;
    ev_lempty_next    = ev_lempty;
    ev_rempty_next    = ev_rempty;
    res_status_next   = res_status;
    res_cost_next     = res_cost;
    res_root_next     = res_root;
    out_load          = 1'b0;
    cram_we           = 1'b0;
    cram_waddr        = '0;
    cram_wdata        = '0;
    cram_raddr_a      = '0;
    cram_raddr_b      = '0;
    pram_we           = 1'b0;
    pram_waddr        = '0;
    pram_wdata        = '0;
    pram_raddr_a      = '0;
    pram_raddr_b      = '0;

    unique case (state)
      obst_pkg::ST_IDLE: begin
        // query address goes out at once, data is used in the next state
        cram_raddr_a = {AB'(q_first - QW'(1)), AB'(q_end - QW'(1))};
        if (in_valid) begin
          res_cost_next = '0;
          res_root_next = '0;
          if (func == obst_pkg::FUNC_LOAD) begin
            if (eff_count >= KB'(MAX_KEYS)) begin
              res_status_next = obst_pkg::STAT_RANGE;
              state_next      = obst_pkg::ST_RESP;
            end else begin
              // single-key range costs its own weight and is its own root
              cram_we           = 1'b1;
              cram_waddr        = {AB'(eff_count), AB'(eff_count)};
              cram_wdata        = {cnt_inc, COST_BITS'(w_in)};
              pram_we           = 1'b1;
              pram_waddr        = AB'(eff_count);
              pram_wdata        = sum_inc;
              key_count_next    = cnt_inc;
              psum_next         = sum_inc;
              tables_ready_next = 1'b0;
              if (last) begin
                res_status_next = obst_pkg::STAT_OK;
                d_next          = KB'(1);
                i0_next         = '0;
                state_next      = (eff_count == '0) ? obst_pkg::ST_FIN_RD
                                                    : obst_pkg::ST_SPAN_RD;
              end else begin
                res_status_next = obst_pkg::STAT_LOADED;
                state_next      = obst_pkg::ST_RESP;
              end
            end
          end else begin
            priority if (!tables_ready) begin
              res_status_next = obst_pkg::STAT_NOT_READY;
              state_next      = obst_pkg::ST_RESP;
            end else if (q_bad) begin
              res_status_next = obst_pkg::STAT_RANGE;
              state_next      = obst_pkg::ST_RESP;
            end else if (q_empty) begin
              res_status_next = obst_pkg::STAT_OK;
              state_next      = obst_pkg::ST_RESP;
            end else begin
              res_status_next = obst_pkg::STAT_OK;
              state_next      = obst_pkg::ST_QUERY;
            end
          end
        end
      end

      obst_pkg::ST_SPAN_RD: begin
        // prefix sums at both ends of the range
        pram_raddr_a = AB'(j0);
        pram_raddr_b = AB'(i0 - KB'(1));
        state_next   = obst_pkg::ST_SPAN;
      end

      obst_pkg::ST_SPAN: begin
        span_next  = pram_rda - ((i0 == '0) ? '0 : pram_rdb);
        k0_next    = i0;
        state_next = obst_pkg::ST_CAND;
      end

      obst_pkg::ST_CAND: begin
        // issue sub-range reads for root k0
        cram_raddr_a   = {AB'(i0), AB'(k0 - KB'(1))};
        cram_raddr_b   = {AB'(k0 + KB'(1)), AB'(j0)};
        ev_valid_next  = 1'b1;
        ev_k_next      = k0;
        ev_lempty_next = (k0 == i0);
        ev_rempty_next = (k0 == j0);
        if (k0 == j0) begin
          state_next = obst_pkg::ST_DRAIN;
        end else begin
          k0_next = k0 + KB'(1);
        end
      end

      obst_pkg::ST_DRAIN: begin
        state_next = obst_pkg::ST_WRITE;
      end

      obst_pkg::ST_WRITE: begin
        // store the winner and step along the diagonal
        cram_we    = 1'b1;
        cram_waddr = {AB'(i0), AB'(j0)};
        cram_wdata = {best_k + KB'(1), best + COST_BITS'(span)};
        if (j0 == key_count - KB'(1)) begin
          if (d == key_count - KB'(1)) begin
            state_next = obst_pkg::ST_FIN_RD;
          end else begin
            d_next     = d + KB'(1);
            i0_next    = '0;
            state_next = obst_pkg::ST_SPAN_RD;
          end
        end else begin
          i0_next    = i0 + KB'(1);
          state_next = obst_pkg::ST_SPAN_RD;
        end
      end

      obst_pkg::ST_FIN_RD: begin
        cram_raddr_a = {AB'(0), AB'(key_count - KB'(1))};
        state_next   = obst_pkg::ST_FIN;
      end

      obst_pkg::ST_FIN: begin
        res_cost_next     = obst_pkg::sat_cost(
                              obst_pkg::COST_CALC_BITS'(cram_rda[COST_BITS-1:0]));
        res_root_next     = obst_pkg::ROOT_OUT_BITS'(cram_rda[CW-1:COST_BITS]);
        tables_ready_next = 1'b1;
        state_next        = obst_pkg::ST_RESP;
      end

      obst_pkg::ST_QUERY: begin
        res_cost_next = obst_pkg::sat_cost(
                          obst_pkg::COST_CALC_BITS'(cram_rda[COST_BITS-1:0]));
        res_root_next = obst_pkg::ROOT_OUT_BITS'(cram_rda[CW-1:COST_BITS]);
        state_next    = obst_pkg::ST_RESP;
      end

      obst_pkg::ST_RESP: begin
        // hand over once the output register is free
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = obst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = obst_pkg::ST_IDLE;
      end
    endcase
  end

  // candidate results only come out of the root scan
  `ASSERT_PROP(a_eval_in_scan, clk, rst, ev_valid |-> (state == obst_pkg::ST_CAND || state == obst_pkg::ST_DRAIN))
  // chosen root lies inside the range being written
  `ASSERT_PROP(a_root_in_range, clk, rst, (state == obst_pkg::ST_WRITE) |-> (best_k >= i0 && best_k <= j0))
  // key count never passes the store size, ready tables always have keys
  `ASSERT_NEVER(a_count_bound, clk, rst, key_count > KB'(MAX_KEYS))
  `ASSERT_NEVER(a_ready_empty, clk, rst, tables_ready && key_count == '0)

endmodule

// ----- rtl/obst_ram.sv -----
// generic ram: one write port, two registered read ports
module obst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- tb/sv/obst_result_checker.sv -----
// result checker for the optimal bst table block: predicts every result and compares it
module obst_result_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                func,
  input  logic [obst_pkg::WEIGHT_IN_BITS-1:0] weight,
  input  logic                                last,
  input  logic [obst_pkg::RANGE_BITS-1:0]     range_first,
  input  logic [obst_pkg::RANGE_BITS-1:0]     range_end,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [obst_pkg::STATUS_BITS-1:0]    status,
  input  logic [obst_pkg::COST_OUT_BITS-1:0]  cost,
  input  logic [obst_pkg::ROOT_OUT_BITS-1:0]  root,
  output int                                  fail_count,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import obst_pkg::*;

  localparam int KEY_SLOTS   = MAX_KEYS_DEF;
  localparam int PREFIX_BITS = WEIGHT_IN_BITS + 5;
  localparam int REPORT_CAP  = 60;

  typedef struct packed {
    logic [STATUS_BITS-1:0]   stat;
    logic [COST_OUT_BITS-1:0] cost_val;
    logic [ROOT_OUT_BITS-1:0] root_key;
  } bst_answer_t;

  // own copy of the block state
  logic [WEIGHT_IN_BITS-1:0] key_wt    [KEY_SLOTS];
  logic [PREFIX_BITS-1:0]    wt_prefix [KEY_SLOTS+1];
  logic [63:0]               best_cost [KEY_SLOTS+2][KEY_SLOTS+1];
  logic [ROOT_OUT_BITS-1:0]  best_root [KEY_SLOTS+2][KEY_SLOTS+1];
  int                        keys_loaded = 0;
  bit                        tables_valid = 1'b0;

  bst_answer_t answers_due [$];
  bst_answer_t want;
  int          fails = 0;

  // diagonal fill of the cost and root tables over the loaded keys
  function automatic void fill_tables();
    int n, i, j, k, d, lowest_k;
    logic [63:0] span, trial, lowest;
    n = keys_loaded;
    for (i = 1; i <= n; i++) begin
      best_cost[i][i-1] = '0;
      best_root[i][i-1] = '0;
      best_cost[i][i]   = 64'(key_wt[i-1]);
      best_root[i][i]   = ROOT_OUT_BITS'(i);
    end
    best_cost[n+1][n] = '0;
    best_root[n+1][n] = '0;
    for (d = 1; d < n; d++) begin
      for (i = 1; i + d <= n; i++) begin
        j = i + d;
        span = 64'(wt_prefix[j]) - 64'(wt_prefix[i-1]);
        lowest = best_cost[i][i-1] + best_cost[i+1][j] + span;
        lowest_k = i;
        // strict compare keeps the smallest root on ties
        for (k = i + 1; k <= j; k++) begin
          trial = best_cost[i][k-1] + best_cost[k+1][j] + span;
          if (trial < lowest) begin
            lowest = trial;
            lowest_k = k;
          end
        end
        best_cost[i][j] = lowest;
        best_root[i][j] = ROOT_OUT_BITS'(lowest_k);
      end
    end
  endfunction

  function automatic logic [COST_OUT_BITS-1:0] clamp_cost(logic [63:0] c);
    if (c > 64'(COST_OUT_MAX)) begin
      return COST_OUT_MAX;
    end
    return c[COST_OUT_BITS-1:0];
  endfunction

  // update the state for one accepted item and work out its result
  function automatic bst_answer_t answer_item(logic f, logic [WEIGHT_IN_BITS-1:0] w, logic lst,
                                              logic [RANGE_BITS-1:0] rf,
                                              logic [RANGE_BITS-1:0] re);
    bst_answer_t a;
    int first_k, end_k;
    a = '0;
    a.stat = STAT_LOADED;
    first_k = int'(rf);
    end_k = int'(re);
    if (f == FUNC_LOAD) begin
      // a load after a finished build opens a new key set
      if (tables_valid) begin
        tables_valid = 1'b0;
        keys_loaded = 0;
      end
      if (keys_loaded >= KEY_SLOTS) begin
        a.stat = STAT_RANGE;
      end else begin
        key_wt[keys_loaded] = w;
        wt_prefix[keys_loaded+1] = wt_prefix[keys_loaded] + PREFIX_BITS'(w);
        keys_loaded++;
        if (lst) begin
          fill_tables();
          tables_valid = 1'b1;
          a.stat = STAT_OK;
          a.cost_val = clamp_cost(best_cost[1][keys_loaded]);
          a.root_key = best_root[1][keys_loaded];
        end
      end
    end else if (!tables_valid) begin
      a.stat = STAT_NOT_READY;
    end else if (first_k < 1 || first_k > keys_loaded + 1 || end_k > keys_loaded ||
                 end_k + 1 < first_k) begin
      a.stat = STAT_RANGE;
    end else begin
      a.stat = STAT_OK;
      a.cost_val = clamp_cost(best_cost[first_k][end_k]);
      a.root_key = best_root[first_k][end_k];
    end
    return a;
  endfunction

  function automatic void flag_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
    fails++;
    if (fails <= REPORT_CAP) begin
      $display("time %0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
    end else if (fails == REPORT_CAP + 1) begin
      $display("time %0t: further mismatches are counted but not shown", $time);
    end
  endfunction

  // watch both channels: predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    if (rst) begin
      keys_loaded = 0;
      tables_valid = 1'b0;
      wt_prefix[0] = '0;
      answers_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        answers_due.push_back(answer_item(func, weight, last, range_first, range_end));
      end
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          fails++;
          $display("time %0t: result transfer with none expected (status %0d cost %0d root %0d)",
                   $time, status, cost, root);
        end else begin
          want = answers_due.pop_front();
          if (status !== want.stat) begin
            flag_mismatch("status", 64'(want.stat), 64'(status));
          end
          if (cost !== want.cost_val) begin
            flag_mismatch("cost", 64'(want.cost_val), 64'(cost));
          end
          if (root !== want.root_key) begin
            flag_mismatch("root", 64'(want.root_key), 64'(root));
          end
        end
      end
    end
    pending <= answers_due.size();
    fail_count <= fails;
  end

endmodule

// ----- tb/sv/optimal_bst_cost_root_tables_tb.sv -----
// testbench top: drives load and query transfers into the optimal bst table block
module optimal_bst_cost_root_tables_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import obst_pkg::*;

  localparam int KEY_SLOTS   = MAX_KEYS_DEF;
  localparam int RAND_ITEMS  = 900;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 40;

  typedef enum {WT_RANDOM, WT_TIES, WT_HEAVY, WT_MIXED} wt_mode_e;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       func = FUNC_LOAD;
  logic [WEIGHT_IN_BITS-1:0]  weight = '0;
  logic                       last = 1'b0;
  logic [RANGE_BITS-1:0]      range_first = '0;
  logic [RANGE_BITS-1:0]      range_end = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [STATUS_BITS-1:0]     status;
  logic [COST_OUT_BITS-1:0]   cost;
  logic [ROOT_OUT_BITS-1:0]   root;

  int mismatch_count;
  int pending_results;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int sets_built = 0;
  int largest_set = 0;
  int keys_held = 0;
  bit set_built = 1'b0;
  int rand_start;

  optimal_bst_cost_root_tables dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .weight      (weight),
    .last        (last),
    .range_first (range_first),
    .range_end   (range_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .cost        (cost),
    .root        (root)
  );

  obst_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .weight      (weight),
    .last        (last),
    .range_first (range_first),
    .range_end   (range_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .cost        (cost),
    .root        (root),
    .fail_count  (mismatch_count),
    .pending     (pending_results)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped by the watchdog after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // one input transfer, with a random gap in front of it
  task automatic send_item(input logic f, input logic [WEIGHT_IN_BITS-1:0] w, input logic lst,
                           input logic [RANGE_BITS-1:0] rf, input logic [RANGE_BITS-1:0] re);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    weight      <= w;
    last        <= lst;
    range_first <= rf;
    range_end   <= re;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (f == FUNC_LOAD) begin
      loads_sent++;
    end else begin
      queries_sent++;
    end
  endtask

  // load one key weight, keeping track of the key set being built
  task automatic load_key(input logic [WEIGHT_IN_BITS-1:0] w, input logic lst);
    if (set_built) begin
      set_built = 1'b0;
      keys_held = 0;
    end
    send_item(FUNC_LOAD, w, lst, RANGE_BITS'($urandom), RANGE_BITS'($urandom));
    keys_held++;
    if (lst) begin
      set_built = 1'b1;
      sets_built++;
      if (keys_held > largest_set) begin
        largest_set = keys_held;
      end
    end
  endtask

  task automatic query_range(input logic [RANGE_BITS-1:0] rf, input logic [RANGE_BITS-1:0] re);
    send_item(FUNC_QUERY, WEIGHT_IN_BITS'($urandom), 1'($urandom), rf, re);
  endtask

  // a key set with stray queries, usually closed by a last load, then a batch of queries
  task automatic run_key_set(input int force_n, input wt_mode_e force_mode);
    int room, n, k, nq, rf, total;
    bit closes;
    wt_mode_e mode;
    logic [WEIGHT_IN_BITS-1:0] w;
    room = set_built ? KEY_SLOTS : KEY_SLOTS - keys_held;
    if (force_n > 0) begin
      n = force_n;
      mode = force_mode;
    end else begin
      // mostly small sets, the largest ones rarely
      k = $urandom_range(0, 99);
      if (k < 60) begin
        n = $urandom_range(1, 6);
      end else if (k < 90) begin
        n = $urandom_range(7, 14);
      end else if (k < 97) begin
        n = $urandom_range(15, 24);
      end else begin
        n = $urandom_range(25, 32);
      end
      mode = wt_mode_e'($urandom_range(0, 3));
    end
    if (n > room) begin
      n = room;
    end
    closes = (n == room) || ($urandom_range(0, 9) != 0);
    for (k = 1; k <= n; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        query_range(RANGE_BITS'($urandom), RANGE_BITS'($urandom));
      end
      case (mode)
        WT_RANDOM: begin
          w = WEIGHT_IN_BITS'($urandom);
        end
        WT_TIES: begin
          w = WEIGHT_IN_BITS'($urandom_range(0, 3));
        end
        WT_HEAVY: begin
          w = '1;
        end
        default: begin
          case ($urandom_range(0, 2))
            0: w = '0;
            1: w = '1;
            default: w = WEIGHT_IN_BITS'($urandom);
          endcase
        end
      endcase
      load_key(w, closes && (k == n));
    end
    total = keys_held;
    nq = $urandom_range(2, 10);
    repeat (nq) begin
      if (set_built && $urandom_range(0, 99) < 75) begin
        rf = $urandom_range(1, total + 1);
        query_range(RANGE_BITS'(rf), RANGE_BITS'($urandom_range(rf - 1, total)));
      end else begin
        query_range(RANGE_BITS'($urandom), RANGE_BITS'($urandom));
      end
    end
  endtask

  // stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 73;

    // query before any tables exist
    query_range(6'd1, 6'd1);
    // single key at full weight, then queries around it
    load_key('1, 1'b1);
    query_range(6'd1, 6'd1);
    query_range(6'd2, 6'd1);
    query_range(6'd1, 6'd0);
    // invalid ranges: first of zero, first past the end, end past the keys, all ones
    query_range(6'd0, 6'd0);
    query_range(6'd3, 6'd1);
    query_range(6'd1, 6'd2);
    query_range('1, '1);
    // new set after a build, with a query while loading, all weights zero
    load_key('0, 1'b0);
    query_range(6'd1, 6'd1);
    load_key('0, 1'b0);
    load_key('0, 1'b1);
    query_range(6'd1, 6'd3);
    query_range(6'd2, 6'd3);
    query_range(6'd3, 6'd1);
    query_range(6'd4, 6'd3);
    // equal weights, roots chosen on ties
    load_key(16'd5, 1'b0);
    load_key(16'd5, 1'b0);
    load_key(16'd5, 1'b0);
    load_key(16'd5, 1'b1);
    query_range(6'd1, 6'd4);
    query_range(6'd2, 6'd4);

    // random part, opened by a full store of the heaviest weights
    rand_start = items_sent;
    run_key_set(KEY_SLOTS, WT_HEAVY);
    while (items_sent - rand_start < RAND_ITEMS) begin
      if (items_sent - rand_start >= 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent - rand_start >= RAND_ITEMS / 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 37;
      end
      run_key_set(0, WT_RANDOM);
    end

    // fill the store without a last load, then push past its end
    while (set_built || keys_held < KEY_SLOTS) load_key(WEIGHT_IN_BITS'($urandom), 1'b0);
    send_item(FUNC_LOAD, '1, 1'b1, RANGE_BITS'($urandom), RANGE_BITS'($urandom));
    send_item(FUNC_LOAD, '0, 1'b0, RANGE_BITS'($urandom), RANGE_BITS'($urandom));
    query_range(6'd1, 6'd32);
    in_valid <= 1'b0;

    // drain outstanding results
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d load and %0d query transfers; %0d key sets built, largest %0d keys",
             loads_sent, queries_sent, sets_built, largest_set);
    $display("idling went receiver-heavy, sender-heavy, then none; ended on a full key store");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/obst_pkg.sv
rtl/obst_ram.sv
rtl/optimal_bst_cost_root_tables.sv
tb/sv/obst_result_checker.sv
tb/sv/optimal_bst_cost_root_tables_tb.sv
